// ----- design/dddf_pkg.sv -----
package dddf_pkg;

   // dither and dac geometry
   localparam int DITHER_BITS  = 2;
   localparam int DAC_BITS     = 12;
   localparam int VALUE_W      = 14;
   localparam int CMD_W        = 2;
   localparam int WORD_W       = 16;
   localparam int PREFIX_W     = 8;
   localparam int CODE_FIELD_W = 12;
   localparam int COUNT_W      = 16;
   localparam int FREQ_W       = 16;
   localparam int SCALE_W      = 8;
   localparam int PRODUCT_W    = COUNT_W + SCALE_W;

   localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};

   localparam logic [PREFIX_W-1:0] VOLT_PREFIX = 8'h10;
   localparam logic [PREFIX_W-1:0] CURR_PREFIX = 8'h90;
   localparam logic [SCALE_W-1:0]  SCALE_RESET = 8'd5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET_VOLT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CURR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LINE_EDGE = 2'd3;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FREQ_SCALE = 1'b0;

   typedef struct packed {
      logic              words_valid;
      logic [WORD_W-1:0] volt_word;
      logic [WORD_W-1:0] curr_word;
      logic [FREQ_W-1:0] line_freq;
   } rsp_type;

   // dithered dac code packed behind its channel prefix
   function automatic logic [WORD_W-1:0] dither_word(
      input logic [DAC_BITS-1:0]    base,
      input logic [DITHER_BITS-1:0] frac,
      input logic [DITHER_BITS-1:0] phase,
      input logic [PREFIX_W-1:0]    prefix
   );
      logic [DAC_BITS-1:0]              code;
      logic [DAC_BITS+CODE_FIELD_W-1:0] code_ext;
      code = base;
      if ((frac > phase) && (base != DAC_MAX)) begin
         code = base + DAC_BITS'(1);
      end
      code_ext = (DAC_BITS + CODE_FIELD_W)'(code);
      return {prefix, {(WORD_W - PREFIX_W){1'b0}}}
             | WORD_W'(code_ext[CODE_FIELD_W-1:0]);
   endfunction

endpackage

// ----- design/dddf_core.sv -----
module dddf_core
   import dddf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [CMD_W-1:0]   cmd,
   input  logic [VALUE_W-1:0] value,
   input  logic [SCALE_W-1:0] freq_scale,
   output rsp_type            result
);

   logic [DAC_BITS-1:0]    volt_base_ff, volt_base_in;
   logic [DITHER_BITS-1:0] volt_frac_ff, volt_frac_in;
   logic [DAC_BITS-1:0]    curr_base_ff, curr_base_in;
   logic [DITHER_BITS-1:0] curr_frac_ff, curr_frac_in;
   logic [DITHER_BITS-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0]     tick_count_ff, tick_count_in;
   logic [FREQ_W-1:0]      freq_value_ff, freq_value_in;

   logic [VALUE_W+DAC_BITS-1:0] value_shift;
   logic [DAC_BITS-1:0]         set_base;
   logic [DITHER_BITS-1:0]      set_frac;
   logic [PRODUCT_W-1:0]        product;

   // upper bits are the base, low bits the fraction
   assign value_shift = (VALUE_W + DAC_BITS)'(value) >> DITHER_BITS;
   assign set_base    = value_shift[DAC_BITS-1:0];
   assign set_frac    = value[DITHER_BITS-1:0];
   assign product     = PRODUCT_W'(tick_count_ff) * PRODUCT_W'(freq_scale);

   always_comb begin
      volt_base_in  = volt_base_ff;
      volt_frac_in  = volt_frac_ff;
      curr_base_in  = curr_base_ff;
      curr_frac_in  = curr_frac_ff;
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      freq_value_in = freq_value_ff;
      result.words_valid = 1'b0;
      result.volt_word   = '0;
      result.curr_word   = '0;
      unique case (cmd)
         CMD_SET_VOLT: begin
            volt_base_in = set_base;
            volt_frac_in = set_frac;
            phase_in     = '0;
         end
         CMD_SET_CURR: begin
            curr_base_in = set_base;
            curr_frac_in = set_frac;
            phase_in     = '0;
         end
         CMD_TICK: begin
            result.words_valid = 1'b1;
            result.volt_word   = dither_word(volt_base_ff, volt_frac_ff, phase_ff, VOLT_PREFIX);
            result.curr_word   = dither_word(curr_base_ff, curr_frac_ff, phase_ff, CURR_PREFIX);
            phase_in      = phase_ff + DITHER_BITS'(1);
            tick_count_in = tick_count_ff + COUNT_W'(1);
         end
         CMD_LINE_EDGE: begin
            freq_value_in = product[FREQ_W-1:0];
            tick_count_in = '0;
         end
         default: begin
         end
      endcase
      result.line_freq = freq_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_base_ff  <= '0;
         volt_frac_ff  <= '0;
         curr_base_ff  <= '0;
         curr_frac_ff  <= '0;
         phase_ff      <= '0;
         tick_count_ff <= '0;
         freq_value_ff <= '0;
      end else if (step) begin
         volt_base_ff  <= volt_base_in;
         volt_frac_ff  <= volt_frac_in;
         curr_base_ff  <= curr_base_in;
         curr_frac_ff  <= curr_frac_in;
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         freq_value_ff <= freq_value_in;
      end
   end

   // a set restarts the dither cycle
   a_set_clears_phase: assert property (@(posedge clock) disable iff (reset)
      step && ((cmd == CMD_SET_VOLT) || (cmd == CMD_SET_CURR)) |=> phase_ff == '0)
      else $error("dither phase not restarted by set");

   // a line edge restarts the tick count
   a_edge_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && (cmd == CMD_LINE_EDGE) |=> tick_count_ff == '0)
      else $error("tick count not cleared by line edge");

endmodule

// ----- design/dddf_outbuf.sv -----
module dddf_outbuf
   import dddf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_push,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_ready
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take     = out_valid_ff && rsp_ready;
   assign can_push = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = push;
         out_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // skid only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

endmodule

// ----- design/dithered_dual_dac_feeder_core.sv -----
// channel  | handshake              | word
// ---------+------------------------+-----------------------------------------------
// req      | req_valid / req_ready  | req_cmd, req_value
// rsp      | rsp_valid / rsp_ready  | rsp_words_valid, rsp_volt_word, rsp_curr_word,
//          |                        | rsp_line_freq
// csr      | psel/penable, pready=1 | paddr, pwrite, pwdata, prdata
//
// one word accepted per cycle while req_ready is high; a result passes through the input
// register, then the result register (or its skid entry)
// every request yields exactly one result word
// a two-entry output buffer (result register plus skid) absorbs one result while
// rsp_ready is low, so requests keep flowing; req_ready drops only once both entries and the
// input register hold a word
// reset is synchronous: clears dither state, counters, valids, freq_scale back to 5
module dithered_dual_dac_feeder_core
   import dddf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [VALUE_W-1:0]    req_value,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_words_valid,
   output logic [WORD_W-1:0]     rsp_volt_word,
   output logic [WORD_W-1:0]     rsp_curr_word,
   output logic [FREQ_W-1:0]     rsp_line_freq,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   in_cmd_ff, in_cmd_in;
   logic [VALUE_W-1:0] in_value_ff, in_value_in;

   logic [SCALE_W-1:0] freq_scale_ff, freq_scale_in;

   logic    buf_ready;
   logic    advance;
   logic    req_take;
   logic    csr_write;
   logic    csr_index;
   rsp_type result;
   rsp_type rsp_data;

   // the held word moves on once the output buffer has room
   assign advance   = in_valid_ff && buf_ready;
   assign req_ready = !in_valid_ff || buf_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_value_in = in_value_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_cmd;
         in_value_in = req_value;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff   <= in_cmd_in;
      in_value_ff <= in_value_in;
   end

   // register file: freq_scale at every address with paddr[2] low, addresses with paddr[2] high read zero
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      freq_scale_in = freq_scale_ff;
      if (csr_write && (csr_index == REG_FREQ_SCALE)) begin
         freq_scale_in = pwdata[SCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_scale_ff <= SCALE_RESET;
      end else begin
         freq_scale_ff <= freq_scale_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == REG_FREQ_SCALE) begin
         prdata = CSR_DATA_W'(freq_scale_ff);
      end
   end

   // dither state, tick counter and frequency latch
   dddf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .cmd        (in_cmd_ff),
      .value      (in_value_ff),
      .freq_scale (freq_scale_ff),
      .result     (result)
   );

   // result register with skid entry
   dddf_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (result),
      .can_push  (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

   assign rsp_words_valid = rsp_data.words_valid;
   assign rsp_volt_word   = rsp_data.volt_word;
   assign rsp_curr_word   = rsp_data.curr_word;
   assign rsp_line_freq   = rsp_data.line_freq;

   // non-tick results carry no dac words
   a_idle_words_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_words_valid |-> (rsp_volt_word == '0) && (rsp_curr_word == '0))
      else $error("dac words set on a non-tick result");

   // the prefix bits above the code field never change on tick words
   a_tick_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_words_valid
         |-> (rsp_volt_word[WORD_W-1:CODE_FIELD_W]
                 == VOLT_PREFIX[PREFIX_W-1:PREFIX_W-(WORD_W-CODE_FIELD_W)])
             && (rsp_curr_word[WORD_W-1:CODE_FIELD_W]
                 == CURR_PREFIX[PREFIX_W-1:PREFIX_W-(WORD_W-CODE_FIELD_W)]))
      else $error("dac word prefix mismatch");

endmodule
